@@ src/ole_pkg.sv @@
// ----------------------------------------------------------------------------
// ole_pkg
// Shared constants, command and status codes, and sequencer states for the
// ordered list engine.
// ----------------------------------------------------------------------------
package ole_pkg;

  localparam int CAPACITY    = 32;
  localparam int DATA_WIDTH  = 32;
  localparam int MAX_RESULTS = 32;

  localparam int AW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW  = $clog2(CAPACITY + 1);
  localparam int PW  = ((CW > 6) ? CW : 6) + 1;

  localparam int CMD_W   = 3;
  localparam int VAL_W   = 32;
  localparam int POS_W   = 6;
  localparam int IN_W    = 48;
  localparam int ELEM_W  = 32;
  localparam int IDX_W   = 5;
  localparam int OUT_W   = 40;

  localparam logic [CMD_W-1:0] CMD_INSERT_AT   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_INSERT_BACK = 3'd1;
  localparam logic [CMD_W-1:0] CMD_DELETE_AT   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DELETE_BACK = 3'd3;
  localparam logic [CMD_W-1:0] CMD_SEARCH      = 3'd4;
  localparam logic [CMD_W-1:0] CMD_TRAVERSE    = 3'd5;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BADPOS = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT_UP,
    S_PUT,
    S_SHIFT_DN,
    S_SEARCH,
    S_TRAV,
    S_RESP
  } state_t;

endpackage

@@ src/ole_ram.sv @@
// ----------------------------------------------------------------------------
// ole_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ole_ram #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 32,
  parameter int AWID  = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AWID-1:0]  waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AWID-1:0]  raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ src/ordered_list_engine.sv @@
// ----------------------------------------------------------------------------
// ordered_list_engine
// Ordered list of signed values kept in one RAM, one command per transaction.
// ----------------------------------------------------------------------------
// One command is taken at a time. Failed commands, unused codes, search of an
// empty list and delete of the last entry go straight to the response. An
// append writes the new entry without shifting. Positional insert and delete
// shift every later entry by one slot, one RAM read and write per cycle. Search
// of n stored entries reads one per cycle. Traverse of n entries gives one
// result per RAM read, and each RAM read waits until the output register is
// free. A result waiting on the output does not keep the next command from
// being taken.
module ordered_list_engine
  import ole_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [IN_W-1:0]   in_tdata,   // command[2:0], item_value[34:3], position[40:35]
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_W-1:0]  out_tdata,  // status[1:0], found[2], element[34:3],
                                        // element_index[39:35]
  output logic              out_tlast
);

  state_t                state_r, state_nxt, acc_state;
  logic [CW-1:0]         count_r, count_nxt, acc_count;
  logic [CW-1:0]         ptr_r, ptr_nxt, acc_ptr;
  logic [CW-1:0]         rem_r, rem_nxt, acc_rem;
  logic [AW-1:0]         wa_r, wa_nxt;
  logic [AW-1:0]         put_r, put_nxt, acc_put;
  logic [DATA_WIDTH-1:0] val_r, val_nxt;
  status_t               status_r, status_nxt, acc_status;
  logic                  found_r, found_nxt;
  logic                  rd_pend_r, rd_pend_nxt;
  logic                  rd_last_r, rd_last_nxt;
  logic [IDX_W-1:0]      rd_idx_r, rd_idx_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]      out_data_r, out_data_nxt;
  logic                  out_last_r, out_last_nxt;

  logic                  ram_we, ram_re;
  logic [AW-1:0]         ram_wa, ram_ra;
  logic [DATA_WIDTH-1:0] ram_wd, ram_rd;
  logic [63:0]           rd_wide;

  logic                  accept, out_free;
  logic [CMD_W-1:0]      in_cmd;
  logic [VAL_W-1:0]      in_val;
  logic [POS_W-1:0]      in_pos;
  logic [63:0]           val_wide;
  logic [PW-1:0]         pos_x, cnt_x, eff_pos;

  assign in_cmd   = in_tdata[2:0];
  assign in_val   = in_tdata[34:3];
  assign in_pos   = in_tdata[40:35];
  assign val_wide = 64'($signed(in_val));
  assign rd_wide  = 64'(ram_rd);
  assign pos_x    = PW'(in_pos);
  assign cnt_x    = PW'(count_r);

  assign in_tready  = (state_r == S_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  ole_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (DATA_WIDTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_wa),
    .wdata (ram_wd),
    .re    (ram_re),
    .raddr (ram_ra),
    .rdata (ram_rd)
  );

  // Command decode against the current fill level
  always_comb begin
    acc_state  = S_RESP;
    acc_status = ST_OK;
    acc_rem    = '0;
    acc_ptr    = '0;
    acc_put    = '0;
    acc_count  = count_r;
    eff_pos    = pos_x;
    unique case (in_cmd)
      CMD_INSERT_AT, CMD_INSERT_BACK: begin
        eff_pos = (in_cmd == CMD_INSERT_BACK) ? (cnt_x + PW'(1)) : pos_x;
        if (eff_pos == '0 || eff_pos > cnt_x + PW'(1)) begin
          acc_status = ST_BADPOS;
        end else if (cnt_x >= PW'(CAPACITY)) begin
          acc_status = ST_FULL;
        end else begin
          acc_rem   = CW'(cnt_x - (eff_pos - PW'(1)));
          acc_ptr   = CW'(cnt_x - PW'(1));
          acc_put   = AW'(eff_pos - PW'(1));
          acc_count = count_r + CW'(1);
          acc_state = (eff_pos == cnt_x + PW'(1)) ? S_PUT : S_SHIFT_UP;
        end
      end
      CMD_DELETE_AT, CMD_DELETE_BACK: begin
        eff_pos = (in_cmd == CMD_DELETE_BACK) ? cnt_x : pos_x;
        if (count_r == '0) begin
          acc_status = ST_EMPTY;
        end else if (eff_pos == '0 || eff_pos > cnt_x) begin
          acc_status = ST_BADPOS;
        end else begin
          acc_rem   = CW'(cnt_x - eff_pos);
          acc_ptr   = CW'(eff_pos);
          acc_count = count_r - CW'(1);
          acc_state = (cnt_x != eff_pos) ? S_SHIFT_DN : S_RESP;
        end
      end
      CMD_SEARCH: begin
        acc_rem   = count_r;
        acc_state = (count_r != '0) ? S_SEARCH : S_RESP;
      end
      CMD_TRAVERSE: begin
        if (count_r == '0) begin
          acc_status = ST_EMPTY;
        end else begin
          acc_rem   = (cnt_x > PW'(MAX_RESULTS)) ? CW'(MAX_RESULTS) : count_r;
          acc_state = S_TRAV;
        end
      end
      default: begin
        acc_state = S_RESP;
      end
    endcase
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:     if (accept) state_nxt = acc_state;
      S_SHIFT_UP: if (rem_r == '0) state_nxt = S_PUT;
      S_PUT:      state_nxt = S_RESP;
      S_SHIFT_DN: if (rem_r == '0) state_nxt = S_RESP;
      S_SEARCH:   if (rem_r == '0 && !rd_pend_r) state_nxt = S_RESP;
      S_TRAV:     if (rd_pend_r && rd_last_r) state_nxt = S_IDLE;
      S_RESP:     if (out_free) state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // Datapath, RAM access and output register
  always_comb begin
    count_nxt     = count_r;
    ptr_nxt       = ptr_r;
    rem_nxt       = rem_r;
    wa_nxt        = wa_r;
    put_nxt       = put_r;
    val_nxt       = val_r;
    status_nxt    = status_r;
    found_nxt     = found_r;
    rd_pend_nxt   = 1'b0;
    rd_last_nxt   = rd_last_r;
    rd_idx_nxt    = rd_idx_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    ram_we        = 1'b0;
    ram_wa        = wa_r;
    ram_wd        = ram_rd;
    ram_re        = 1'b0;
    ram_ra        = ptr_r[AW-1:0];
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          count_nxt  = acc_count;
          ptr_nxt    = acc_ptr;
          rem_nxt    = acc_rem;
          put_nxt    = acc_put;
          val_nxt    = val_wide[DATA_WIDTH-1:0];
          status_nxt = acc_status;
          found_nxt  = 1'b0;
        end
      end
      S_SHIFT_UP: begin
        ram_we = rd_pend_r;
        if (rem_r != '0) begin
          ram_re      = 1'b1;
          rd_pend_nxt = 1'b1;
          wa_nxt      = AW'(ptr_r + CW'(1));
          ptr_nxt     = ptr_r - CW'(1);
          rem_nxt     = rem_r - CW'(1);
        end
      end
      S_PUT: begin
        ram_we = 1'b1;
        ram_wa = put_r;
        ram_wd = val_r;
      end
      S_SHIFT_DN: begin
        ram_we = rd_pend_r;
        if (rem_r != '0) begin
          ram_re      = 1'b1;
          rd_pend_nxt = 1'b1;
          wa_nxt      = AW'(ptr_r - CW'(1));
          ptr_nxt     = ptr_r + CW'(1);
          rem_nxt     = rem_r - CW'(1);
        end
      end
      S_SEARCH: begin
        if (rd_pend_r && ram_rd == val_r) begin
          found_nxt = 1'b1;
        end
        if (rem_r != '0) begin
          ram_re      = 1'b1;
          rd_pend_nxt = 1'b1;
          ptr_nxt     = ptr_r + CW'(1);
          rem_nxt     = rem_r - CW'(1);
        end
      end
      S_TRAV: begin
        if (rd_pend_r) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {rd_idx_r, rd_wide[ELEM_W-1:0], 1'b0, ST_OK};
          out_last_nxt  = rd_last_r;
        end else if (rem_r != '0 && out_free) begin
          ram_re      = 1'b1;
          rd_pend_nxt = 1'b1;
          rd_last_nxt = (rem_r == CW'(1));
          rd_idx_nxt  = IDX_W'(ptr_r);
          ptr_nxt     = ptr_r + CW'(1);
          rem_nxt     = rem_r - CW'(1);
        end
      end
      S_RESP: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {IDX_W'(0), ELEM_W'(0), found_r, status_r};
          out_last_nxt  = 1'b1;
        end
      end
      default: begin
        rd_pend_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r      <= ptr_nxt;
    rem_r      <= rem_nxt;
    wa_r       <= wa_nxt;
    put_r      <= put_nxt;
    val_r      <= val_nxt;
    status_r   <= status_nxt;
    found_r    <= found_nxt;
    rd_last_r  <= rd_last_nxt;
    rd_idx_r   <= rd_idx_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

endmodule

@@ sim/tb_ordered_list_engine.sv @@
// ----------------------------------------------------------------------------
// tb_ordered_list_engine
// Self-checking bench for the ordered list engine. A shadow copy of the list
// predicts every result of each accepted command, and a scoreboard compares
// the results in order, field by field. Stimulus is a short directed pass over
// the corner cases, then random phases aimed at a full, an empty and a random
// fill level in turn. Sender bursts and receiver stalls are randomized.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

import ole_pkg::*;

typedef struct packed {
  status_t           status;
  logic              found;
  logic [ELEM_W-1:0] element;
  logic [IDX_W-1:0]  element_index;
  logic              last;
} list_result_t;

class list_scoreboard;
  logic [DATA_WIDTH-1:0] shadow_list[$];
  list_result_t          awaited_results[$];
  int unsigned           errors;

  function new();
    errors = 0;
  endfunction

  function int unsigned depth();
    return shadow_list.size();
  endfunction

  function int unsigned pending();
    return awaited_results.size();
  endfunction

  function logic [DATA_WIDTH-1:0] entry(int unsigned i);
    return shadow_list[i];
  endfunction

  function void push_result(status_t st, logic fnd, logic [ELEM_W-1:0] elem,
                            logic [IDX_W-1:0] idx, logic lst);
    list_result_t r;
    r.status        = st;
    r.found         = fnd;
    r.element       = elem;
    r.element_index = idx;
    r.last          = lst;
    awaited_results.push_back(r);
  endfunction

  function status_t insert_entry(int unsigned pos, logic [DATA_WIDTH-1:0] v);
    if (pos < 1 || pos > shadow_list.size() + 1) return ST_BADPOS;
    if (shadow_list.size() >= CAPACITY) return ST_FULL;
    shadow_list.insert(pos - 1, v);
    return ST_OK;
  endfunction

  function status_t remove_entry(int unsigned pos);
    if (shadow_list.size() == 0) return ST_EMPTY;
    if (pos < 1 || pos > shadow_list.size()) return ST_BADPOS;
    shadow_list.delete(pos - 1);
    return ST_OK;
  endfunction

  function void note_command(logic [CMD_W-1:0] cmd, logic [VAL_W-1:0] v,
                             logic [POS_W-1:0] pos);
    int unsigned n;
    logic        hit;
    case (cmd)
      CMD_INSERT_AT:   push_result(insert_entry(pos, v), 1'b0, '0, '0, 1'b1);
      CMD_INSERT_BACK: push_result(insert_entry(shadow_list.size() + 1, v), 1'b0, '0, '0, 1'b1);
      CMD_DELETE_AT:   push_result(remove_entry(pos), 1'b0, '0, '0, 1'b1);
      CMD_DELETE_BACK: push_result(remove_entry(shadow_list.size()), 1'b0, '0, '0, 1'b1);
      CMD_SEARCH: begin
        hit = 1'b0;
        foreach (shadow_list[i]) if (shadow_list[i] == v) hit = 1'b1;
        push_result(ST_OK, hit, '0, '0, 1'b1);
      end
      CMD_TRAVERSE: begin
        if (shadow_list.size() == 0) begin
          push_result(ST_EMPTY, 1'b0, '0, '0, 1'b1);
        end else begin
          n = (shadow_list.size() > MAX_RESULTS) ? MAX_RESULTS : shadow_list.size();
          for (int unsigned i = 0; i < n; i++)
            push_result(ST_OK, 1'b0, shadow_list[i][ELEM_W-1:0], i[IDX_W-1:0], i + 1 == n);
        end
      end
      default: push_result(ST_OK, 1'b0, '0, '0, 1'b1);
    endcase
  endfunction

  function void check_result(list_result_t got);
    list_result_t want;
    if (awaited_results.size() == 0) begin
      errors++;
      $error("unexpected result: status %0d, element %0d, last %0d",
             got.status, $signed(got.element), got.last);
      return;
    end
    want = awaited_results.pop_front();
    if (got.status != want.status) begin
      errors++;
      $error("status: expected %0d, got %0d", want.status, got.status);
    end
    if (got.found != want.found) begin
      errors++;
      $error("found: expected %0d, got %0d", want.found, got.found);
    end
    if (got.element != want.element) begin
      errors++;
      $error("element: expected %0d, got %0d", $signed(want.element), $signed(got.element));
    end
    if (got.element_index != want.element_index) begin
      errors++;
      $error("element_index: expected %0d, got %0d", want.element_index, got.element_index);
    end
    if (got.last != want.last) begin
      errors++;
      $error("last: expected %0d, got %0d", want.last, got.last);
    end
  endfunction
endclass

module tb_ordered_list_engine;

  localparam logic [CMD_W-1:0] CMD_RSVD_6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_RSVD_7 = 3'd7;
  localparam int IDLE_LIMIT   = 4000;
  localparam int DRAIN_CYCLES = 80;
  localparam int RANDOM_ITEMS = 260;

  logic             clk        = 1'b0;
  logic             rst_n      = 1'b0;
  logic             in_tvalid  = 1'b0;
  logic [IN_W-1:0]  in_tdata   = '0;
  logic             out_tready = 1'b0;
  logic             in_tready;
  logic             out_tvalid;
  logic [OUT_W-1:0] out_tdata;
  logic             out_tlast;

  list_scoreboard   list_sb;
  int unsigned      burst_left  = 0;
  int unsigned      idle_cycles = 0;
  logic [15:0]      rx_cycle    = '0;

  ordered_list_engine dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // receiver: rotate through stall patterns on a free-running cycle counter
  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1'b1;
    case (rx_cycle[8:7])
      2'd0:    out_tready <= 1'b1;
      2'd1:    out_tready <= (rx_cycle % 3 == 0);
      2'd2:    out_tready <= ($urandom_range(0, 1) != 0);
      default: out_tready <= ($urandom_range(0, 4) != 0);
    endcase
  end

  always @(posedge clk) begin
    list_result_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.status        = status_t'(out_tdata[1:0]);
      got.found         = out_tdata[2];
      got.element       = out_tdata[34:3];
      got.element_index = out_tdata[39:35];
      got.last          = out_tlast;
      list_sb.check_result(got);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [VAL_W-1:0] v,
                              input logic [POS_W-1:0] pos);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? 48 : $urandom_range(1, 12);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= {7'b0, pos, v, cmd};
    do @(posedge clk); while (!in_tready);
    list_sb.note_command(cmd, v, pos);
  endtask

  // hold off the sender until every pending result is back
  task automatic wait_for_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (list_sb.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 5))
      0:       return ($urandom_range(0, 1) != 0) ? 32'h7fff_ffff : 32'h8000_0000;
      1:       return 32'(int'($urandom_range(0, 16)) - 8);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [POS_W-1:0] pick_position(int unsigned valid_hi);
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1 || valid_hi == 0) return POS_W'($urandom_range(valid_hi + 1, 63));
    return POS_W'($urandom_range(1, valid_hi));
  endfunction

  task automatic random_command(input int unsigned target);
    int unsigned      r;
    int unsigned      n;
    int unsigned      t[6];
    logic [VAL_W-1:0] v;
    n = list_sb.depth();
    r = $urandom_range(0, 99);
    if (n < target) t = '{45, 65, 75, 80, 90, 97};
    else            t = '{15, 25, 55, 70, 85, 97};
    v = pick_value();
    if (r < t[0]) begin
      send_command(CMD_INSERT_AT, v, pick_position(n + 1));
    end else if (r < t[1]) begin
      send_command(CMD_INSERT_BACK, v, POS_W'($urandom()));
    end else if (r < t[2]) begin
      send_command(CMD_DELETE_AT, v, pick_position(n));
    end else if (r < t[3]) begin
      send_command(CMD_DELETE_BACK, v, POS_W'($urandom()));
    end else if (r < t[4]) begin
      if (n != 0 && $urandom_range(0, 1) != 0) v = list_sb.entry($urandom_range(0, n - 1));
      send_command(CMD_SEARCH, v, POS_W'($urandom()));
    end else if (r < t[5]) begin
      send_command(CMD_TRAVERSE, v, POS_W'($urandom()));
    end else begin
      send_command(($urandom_range(0, 1) != 0) ? CMD_RSVD_6 : CMD_RSVD_7, v,
                   POS_W'($urandom()));
    end
  endtask

  initial begin
    int unsigned sent;
    int unsigned phase;
    int unsigned phase_len;
    int unsigned target;
    list_sb = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_command(CMD_TRAVERSE,    32'h0,         6'd0);
    send_command(CMD_DELETE_BACK, 32'h0,         6'd0);
    send_command(CMD_DELETE_AT,   32'h0,         6'd0);
    send_command(CMD_INSERT_AT,   32'h1234_5678, 6'd0);
    send_command(CMD_INSERT_AT,   32'h1234_5678, 6'd2);
    send_command(CMD_INSERT_AT,   32'hffff_ffff, 6'd63);
    send_command(CMD_INSERT_AT,   32'h7fff_ffff, 6'd1);
    send_command(CMD_INSERT_BACK, 32'h8000_0000, 6'd0);
    send_command(CMD_INSERT_AT,   32'h0,         6'd3);
    send_command(CMD_INSERT_AT,   32'hffff_ffff, 6'd1);
    send_command(CMD_INSERT_AT,   32'h5555_aaaa, 6'd2);
    send_command(CMD_SEARCH,      32'h8000_0000, 6'd0);
    send_command(CMD_SEARCH,      32'h1234_5678, 6'd0);
    send_command(CMD_SEARCH,      32'hffff_ffff, 6'd63);
    send_command(CMD_TRAVERSE,    32'h0,         6'd0);
    send_command(CMD_DELETE_AT,   32'h0,         6'd0);
    send_command(CMD_DELETE_AT,   32'h0,         6'd6);
    send_command(CMD_DELETE_AT,   32'h0,         6'd1);
    send_command(CMD_DELETE_AT,   32'h0,         6'd3);
    send_command(CMD_DELETE_BACK, 32'h0,         6'd0);
    send_command(CMD_RSVD_6,      32'hffff_ffff, 6'd63);
    send_command(CMD_RSVD_7,      32'h0,         6'd1);
    send_command(CMD_TRAVERSE,    32'h0,         6'd0);
    wait_for_results();

    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      case (phase % 3)
        0:       target = CAPACITY;
        1:       target = 0;
        default: target = $urandom_range(1, CAPACITY - 1);
      endcase
      phase_len = (phase == 0) ? 70 : $urandom_range(30, 60);
      for (int unsigned i = 0; i < phase_len && sent < RANDOM_ITEMS; i++) begin
        random_command(target);
        sent++;
      end
      wait_for_results();
      phase++;
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (list_sb.errors == 0 && list_sb.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
